// ===== hw/rtl/bda_pkg.sv =====
// types, constants and helpers shared by the button debounce and auto-repeat block
package bda_pkg;

  localparam int BUTTON_W        = 2;
  localparam int ACTION_W        = 2;
  localparam int TICKS_W         = 16;
  localparam int MASK_W          = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int DEF_NUM_BUTTONS = 4;

  localparam logic [TICKS_W-1:0] DEF_DEBOUNCE     = 16'd50;
  localparam logic [TICKS_W-1:0] DEF_FIRST_REPEAT = 16'd500;
  localparam logic [TICKS_W-1:0] DEF_REPEAT       = 16'd10;
  localparam logic [MASK_W-1:0]  DEF_REPEAT_MASK  = 4'd3;

  // buttons at or above this index never repeat
  localparam int REPEAT_BUTTONS = 4;

  typedef enum logic {
    OP_LEVEL = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_REPEAT   = 2'd2
  } phase_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_REPEAT  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_FIRST_REPEAT = 2'd1,
    REG_REPEAT       = 2'd2,
    REG_REPEAT_MASK  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RPT_UPD,
    ST_SCAN_RD,
    ST_SCAN_UPD,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic               level;
    phase_t             phase;
    logic [TICKS_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [TICKS_W-1:0] debounce;
    logic [TICKS_W-1:0] first_repeat;
    logic [TICKS_W-1:0] repeat_period;
    logic [MASK_W-1:0]  repeat_mask;
  } cfg_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] button;
    action_t             action;
    logic                last;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } push_t;

  // a zero period behaves as one tick
  function automatic logic [TICKS_W-1:0] load_value(input logic [TICKS_W-1:0] period);
    load_value = (period == '0) ? TICKS_W'(1) : period;
  endfunction

endpackage

// ===== hw/rtl/bda_in_if.sv =====
// request channel carrying level reports and ticks
interface bda_in_if;
  import bda_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [BUTTON_W-1:0] button;
  logic                level;

  modport source (output valid, output operation, output button, output level, input ready);
  modport sink   (input valid, input operation, input button, input level, output ready);
endinterface

// ===== hw/rtl/bda_out_if.sv =====
// result channel carrying button events
interface bda_out_if;
  import bda_pkg::*;

  logic                valid;
  logic                ready;
  logic [BUTTON_W-1:0] event_button;
  logic [ACTION_W-1:0] action;
  logic                last;

  modport source (output valid, output event_button, output action, output last, input ready);
  modport sink   (input valid, input event_button, input action, input last, output ready);
endinterface

// ===== hw/rtl/bda_mem.sv =====
// per-button state memory, one read and one write port, registered read data
module bda_mem #(
  parameter int NUM_BUTTONS = bda_pkg::DEF_NUM_BUTTONS,
  parameter int IDX_W       = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output bda_pkg::entry_t  rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  bda_pkg::entry_t  wr_data
);
  import bda_pkg::*;

  entry_t mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] written_r;
  entry_t rd_mem_r;
  logic   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  // never-written entries read as the reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_mem_r : '0;

endmodule

// ===== hw/rtl/bda_obuf.sv =====
// one-entry output register for events
module bda_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  bda_pkg::push_t  push,
  output logic            slot_free,
  bda_out_if.source       out_chan
);
  import bda_pkg::*;

  logic   out_vld_r;
  event_t ev_r;

  assign slot_free = !out_vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ev_r <= push.ev;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.event_button = ev_r.button;
  assign out_chan.action       = ev_r.action;
  assign out_chan.last         = ev_r.last;

endmodule

// ===== hw/rtl/bda_ctrl.sv =====
// sequencer: read-modify-write of button entries for level reports and tick scans
module bda_ctrl #(
  parameter int NUM_BUTTONS = bda_pkg::DEF_NUM_BUTTONS,
  parameter int IDX_W       = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  bda_in_if.sink           in_chan,
  input  bda_pkg::cfg_t    cfg,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  bda_pkg::entry_t  rd_data,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output bda_pkg::entry_t  wr_data,
  output bda_pkg::push_t   push,
  input  logic             slot_free
);
  import bda_pkg::*;

  ctrl_state_t         state_r, state_nxt;
  logic [BUTTON_W-1:0] button_r;
  logic                level_r;
  logic [IDX_W-1:0]    cnt_r;
  logic                pend_vld_r;
  event_t              pend_r;

  logic   in_range;
  logic   accept;
  logic   last_idx;
  entry_t rpt_entry;
  logic   rpt_release;
  entry_t scan_entry;
  logic   active;
  logic   expire;
  logic   rep_en;
  event_t scan_ev;
  logic   rpt_hold;
  logic   scan_hold;
  logic   flush_hold;

  assign in_range = int'(in_chan.button) < NUM_BUTTONS;
  assign accept   = (state_r == ST_IDLE) && in_chan.valid;
  assign last_idx = cnt_r == IDX_W'(NUM_BUTTONS - 1);

  // entry update
  always_comb begin
    rpt_entry       = '0;
    rpt_entry.level = rd_data.level;
    rpt_release     = 1'b0;
    if (level_r != rd_data.level) begin
      rpt_entry.level = level_r;
      if (level_r) begin
        rpt_entry.phase = PH_DEBOUNCE;
        rpt_entry.count = load_value(cfg.debounce);
      end else begin
        rpt_release = 1'b1;
      end
    end

    active = (rd_data.phase == PH_DEBOUNCE) || (rd_data.phase == PH_REPEAT);
    expire = active && (rd_data.count <= TICKS_W'(1));
    rep_en = (int'(cnt_r) < REPEAT_BUTTONS) && cfg.repeat_mask[2'(cnt_r)];

    scan_entry = rd_data;
    if (active && !expire) begin
      scan_entry.count = rd_data.count - TICKS_W'(1);
    end else if (expire && rd_data.phase == PH_DEBOUNCE) begin
      if (rep_en) begin
        scan_entry.phase = PH_REPEAT;
        scan_entry.count = load_value(cfg.first_repeat);
      end else begin
        scan_entry.phase = PH_IDLE;
        scan_entry.count = '0;
      end
    end else if (expire) begin
      scan_entry.count = load_value(cfg.repeat_period);
    end

    scan_ev.button = BUTTON_W'(cnt_r);
    scan_ev.action = (rd_data.phase == PH_DEBOUNCE) ? ACT_PRESS : ACT_REPEAT;
    scan_ev.last   = 1'b0;

    rpt_hold   = (state_r == ST_RPT_UPD) && rpt_release && !slot_free;
    scan_hold  = (state_r == ST_SCAN_UPD) && expire && pend_vld_r && !slot_free;
    flush_hold = (state_r == ST_FLUSH) && pend_vld_r && !slot_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_chan.operation == OP_TICK) begin
            state_nxt = ST_SCAN_RD;
          end else if (in_range) begin
            state_nxt = ST_RPT_UPD;
          end
        end
      end
      ST_RPT_UPD: begin
        if (!rpt_hold) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_UPD;
      end
      ST_SCAN_UPD: begin
        if (!scan_hold) begin
          state_nxt = last_idx ? ST_FLUSH : ST_SCAN_RD;
        end
      end
      ST_FLUSH: begin
        if (!flush_hold) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    rd_en         = 1'b0;
    rd_addr       = cnt_r;
    wr_en         = 1'b0;
    wr_addr       = IDX_W'(button_r);
    wr_data       = rpt_entry;
    push          = '0;
    case (state_r)
      ST_IDLE: begin
        rd_addr = IDX_W'(in_chan.button);
        rd_en   = accept && (in_chan.operation == OP_LEVEL) && in_range;
      end
      ST_RPT_UPD: begin
        wr_en = !rpt_hold;
        if (rpt_release && slot_free) begin
          push.valid     = 1'b1;
          push.ev.button = button_r;
          push.ev.action = ACT_RELEASE;
          push.ev.last   = 1'b1;
        end
      end
      ST_SCAN_RD: begin
        rd_en = 1'b1;
      end
      ST_SCAN_UPD: begin
        wr_addr = cnt_r;
        wr_data = scan_entry;
        wr_en   = active && !scan_hold;
        if (expire && pend_vld_r && slot_free) begin
          push.valid = 1'b1;
          push.ev    = pend_r;
        end
      end
      ST_FLUSH: begin
        if (pend_vld_r && slot_free) begin
          push.valid   = 1'b1;
          push.ev      = pend_r;
          push.ev.last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pend_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        pend_vld_r <= 1'b0;
      end else if (state_r == ST_SCAN_UPD && !scan_hold && expire) begin
        pend_vld_r <= 1'b1;
      end else if (state_r == ST_FLUSH && !flush_hold) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      button_r <= in_chan.button;
      level_r  <= in_chan.level;
      cnt_r    <= '0;
    end else if (state_r == ST_SCAN_UPD && !scan_hold) begin
      cnt_r <= cnt_r + IDX_W'(1);
      if (expire) begin
        pend_r <= scan_ev;
      end
    end
  end

endmodule

// ===== hw/rtl/button_debounce_autorepeat.sv =====
// top level of the button debounce and auto-repeat block
//
// Qualifies level reports of up to NUM_BUTTONS buttons against a millisecond
// tick. A request is either a level report for one button or a tick. A press
// edge arms a debounce countdown; when a tick finds it expired a press event
// goes out and, for a button whose bit in repeat_mask is set, the
// first-repeat countdown starts, after which repeat events follow every
// repeat_period ticks. A release edge gives a release event at once. Any
// level report, changed or not, stops that button's running countdown.
// Events caused by one request leave in ascending button order, the final
// one with last set. A request can be held while the result side holds off
// a waiting event. Per-button state lives in a small memory with one read
// and one write port and a registered read; every request reads each entry
// it touches and then writes it back, a tick only where a countdown runs,
// and a new request is taken only once the last one is through. Reset clears
// the state at once through per-entry written flags, so no clearing pass is
// needed. Configuration writes go through the cfg_ port and are meant for
// idle periods only; a countdown already running keeps the value it was
// loaded with, and a period of zero acts as one tick.
module button_debounce_autorepeat #(
  parameter int NUM_BUTTONS = bda_pkg::DEF_NUM_BUTTONS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bda_in_if.sink                            in_chan,
  bda_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [bda_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bda_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bda_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  cfg_t             cfg_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  push_t            push;
  logic             slot_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce      <= DEF_DEBOUNCE;
      cfg_r.first_repeat  <= DEF_FIRST_REPEAT;
      cfg_r.repeat_period <= DEF_REPEAT;
      cfg_r.repeat_mask   <= DEF_REPEAT_MASK;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_DEBOUNCE:     cfg_r.debounce      <= cfg_wdata[TICKS_W-1:0];
        REG_FIRST_REPEAT: cfg_r.first_repeat  <= cfg_wdata[TICKS_W-1:0];
        REG_REPEAT:       cfg_r.repeat_period <= cfg_wdata[TICKS_W-1:0];
        REG_REPEAT_MASK:  cfg_r.repeat_mask   <= cfg_wdata[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer doing read-modify-write on the state memory
  bda_ctrl #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .slot_free (slot_free)
  );

  // level, timer phase and countdown of each button
  bda_mem #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // event register toward the result side
  bda_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

`ifndef SYNTH
  // a read and a write never hit the same entry in one cycle
  a_no_rw_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("state memory read and write collide");

  // the sequencer only hands over an event when the output register can take it
  a_push_slot : assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> slot_free)
    else $error("event pushed into a full output register");

  // a release is the only event of its request
  a_release_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.action == ACT_RELEASE) |-> out_chan.last)
    else $error("release event without last");
`endif

endmodule
